### sv/orientation_gated_hit_classifier_top_macros.svh
// Assertion macros for the orientation gated hit classifier.
`ifndef ORIENTATION_GATED_HIT_CLASSIFIER_TOP_MACROS_SVH
`define ORIENTATION_GATED_HIT_CLASSIFIER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define OGHC_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`define OGHC_ASSERT_NR(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define OGHC_ASSERT(lbl, ck, rs, prop, msg)
`define OGHC_ASSERT_NR(lbl, ck, prop, msg)
`endif
`endif

### sv/oghc_pkg.sv
// Shared constants, widths and the CORDIC angle table.
package oghc_pkg;

  localparam int ANGLE_FRAC_BITS = 6;
  localparam int CORDIC_STEPS    = 16;
  localparam int TABLE_LEN       = 24;
  localparam int NSTEP   = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int CNT_W   = $clog2(NSTEP);

  localparam int DW      = 40;            // CORDIC x/y datapath
  localparam int ZW      = 26;            // angle accumulator, Q16 degrees
  localparam int SH      = 16 - ANGLE_FRAC_BITS;
  localparam int UNIT_W  = ANGLE_FRAC_BITS + 10;
  localparam int WRAP_W  = ((ANGLE_FRAC_BITS + 10 > 16) ? ANGLE_FRAC_BITS + 10 : 16) + 2;
  localparam int ISQ_STEPS = 29;

  localparam logic signed [ZW-1:0] Z90 = ZW'(90 * 65536);
  localparam logic signed [WRAP_W-1:0] FULL = WRAP_W'(360 << ANGLE_FRAC_BITS);
  localparam logic signed [WRAP_W-1:0] Y20  = WRAP_W'(20 << ANGLE_FRAC_BITS);
  localparam logic signed [WRAP_W-1:0] Y120 = WRAP_W'(120 << ANGLE_FRAC_BITS);
  localparam logic signed [WRAP_W-1:0] Y200 = WRAP_W'(200 << ANGLE_FRAC_BITS);
  localparam logic signed [WRAP_W-1:0] Y305 = WRAP_W'(305 << ANGLE_FRAC_BITS);
  localparam logic signed [WRAP_W-1:0] Y340 = WRAP_W'(340 << ANGLE_FRAC_BITS);
  localparam logic signed [UNIT_W-1:0] P30  = UNIT_W'(30 << ANGLE_FRAC_BITS);
  localparam logic signed [UNIT_W-1:0] P50  = UNIT_W'(50 << ANGLE_FRAC_BITS);
  localparam logic signed [UNIT_W-1:0] P90  = UNIT_W'(90 << ANGLE_FRAC_BITS);

  localparam logic [1:0] MODE_ORIENT = 2'd0;
  localparam logic [1:0] MODE_GYRO   = 2'd1;

  localparam logic REG_YAW_OFFSET    = 1'b0;
  localparam logic REG_HIT_THRESHOLD = 1'b1;

  localparam logic [2:0] PAD_NONE  = 3'd0;
  localparam logic [2:0] PAD_SNARE = 3'd1;
  localparam logic [2:0] PAD_CRASH = 3'd2;
  localparam logic [2:0] PAD_HTOM  = 3'd3;
  localparam logic [2:0] PAD_RIDE  = 3'd4;
  localparam logic [2:0] PAD_MTOM  = 3'd5;
  localparam logic [2:0] PAD_LTOM  = 3'd6;

  // atan(2^-i) in Q16 degrees
  function automatic logic [21:0] atan_q16(input logic [4:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

### sv/oghc_cordic.sv
// Iterative vectoring CORDIC: atan2(y, x) returned in output angle units.
module oghc_cordic (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [oghc_pkg::DW-1:0] x_in,
  input  logic signed [oghc_pkg::DW-1:0] y_in,
  output logic                          done,
  output logic signed [oghc_pkg::UNIT_W-1:0] units
);
  import oghc_pkg::*;

  logic signed [DW-1:0] x, y, dx, dy;
  logic signed [ZW-1:0] z, zr, at;
  logic [CNT_W-1:0]     cnt;
  logic                 run;

  assign dx = y >>> cnt;
  assign dy = x >>> cnt;
  assign at = ZW'({1'b0, atan_q16(5'(cnt))});
  assign zr = (z + (ZW'(1) <<< (SH - 1))) >>> SH;
  assign units = zr[UNIT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (x_in == '0 && y_in == '0) begin
          z    <= '0;
          done <= 1'b1;
        end else begin
          run <= 1'b1;
          cnt <= '0;
          if (x_in < 0) begin
            if (y_in >= 0) begin
              x <= y_in;  y <= -x_in; z <= Z90;
            end else begin
              x <= -y_in; y <= x_in;  z <= -Z90;
            end
          end else begin
            x <= x_in; y <= y_in; z <= '0;
          end
        end
      end else if (run) begin
        if (y > 0) begin
          x <= x + dx; y <= y - dy; z <= z + at;
        end else begin
          x <= x - dx; y <= y + dy; z <= z - at;
        end
        if (cnt == CNT_W'(NSTEP - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

### sv/orientation_gated_hit_classifier_top.sv
// Top level: quaternion to yaw/pitch sequencer, gyro hit detect, zone classify.
//
//  channel | dir | words                         | handshake
//  s_*     | in  | quaternion, gyro or other     | tvalid/tready
//  m_*     | out | one result word per input    | tvalid/tready
//  cfg_*   | in  | yaw_offset, hit_threshold     | write enable only
//
// A gyro or other word goes straight to FIN. An orientation word runs six products
// and a square on one shared multiplier, a bit-per-step square root, two CORDIC
// runs of 16 steps on one shared unit and a yaw wrap. Saturated pitch skips the
// root and first CORDIC run.
// Reset (rst, synchronous) clears state, flags and config to defaults.
// A waiting result in the output register does not block the next input; it holds FIN.
`include "orientation_gated_hit_classifier_top_macros.svh"
module orientation_gated_hit_classifier_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // q_real, q_i, q_j, q_k, rate_y
  input  logic [1:0]  s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // drum, hit_active, yaw_now, pitch_now, zero pad
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_data
);
  import oghc_pkg::*;

  typedef enum logic [3:0] {
    IDLE, MUL, SQ, SQW, ISQ, PST, PWT, YST, YWT, WRAP, FIN
  } state_t;

  state_t state;

  logic [14:0]        yaw_offset;
  logic signed [15:0] hit_threshold;

  logic [1:0]         mode;
  logic signed [15:0] qr, qi, qj, qk, rate;
  logic [2:0]         mcnt;
  logic [4:0]         icnt;

  logic signed [28:0] mul_a, mul_b;
  logic signed [57:0] prod;
  logic signed [33:0] acc_p, acc_y, acc_c, p34;
  logic signed [34:0] sinp, siny, cosy;

  logic [56:0] isq_v, isq_res, isq_one;
  logic [57:0] isq_t;

  logic                      cord_start, cord_done;
  logic signed [DW-1:0]      cord_x, cord_y;
  logic signed [UNIT_W-1:0]  cord_units;

  logic signed [WRAP_W-1:0] wrap_v, held_yaw;
  logic signed [UNIT_W-1:0] held_pitch;
  logic latched, hit_flag;
  logic [2:0] last_drum;

  logic       fire, rearm, hit_n, fast_in;
  logic [2:0] drum_v, zone;

  assign s_tready = (state == IDLE);
  assign fast_in  = s_tvalid && s_tready && (s_tuser != MODE_ORIENT);

  assign sinp = {acc_p, 1'b0};
  assign siny = {acc_y, 1'b0};
  assign cosy = 35'sd268435456 - {acc_c, 1'b0};
  assign p34  = prod[33:0];
  assign isq_t = {1'b0, isq_res} + {1'b0, isq_one};

  always_comb begin
    mul_a = 29'(qr);
    mul_b = 29'(qj);
    if (state == SQ) begin
      mul_a = sinp[28:0];
      mul_b = sinp[28:0];
    end else begin
      case (mcnt)
        3'd1: begin mul_a = 29'(qk); mul_b = 29'(qi); end
        3'd2: begin mul_a = 29'(qr); mul_b = 29'(qk); end
        3'd3: begin mul_a = 29'(qi); mul_b = 29'(qj); end
        3'd4: begin mul_a = 29'(qj); mul_b = 29'(qj); end
        3'd5: begin mul_a = 29'(qk); mul_b = 29'(qk); end
        default: begin mul_a = 29'(qr); mul_b = 29'(qj); end
      endcase
    end
  end

  assign cord_start = (state == PST) || (state == YST);
  assign cord_x = (state == PST) ? DW'(signed'({1'b0, isq_res[28:0]})) : DW'(cosy);
  assign cord_y = (state == PST) ? DW'(sinp) : DW'(siny);

  oghc_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cord_start),
    .x_in  (cord_x),
    .y_in  (cord_y),
    .done  (cord_done),
    .units (cord_units)
  );

  // zones, bounds inclusive, first match wins
  always_comb begin
    if (held_yaw >= Y20 && held_yaw <= Y120)
      zone = PAD_SNARE;
    else if (held_yaw >= Y340 || held_yaw <= Y20)
      zone = (held_pitch > P50) ? PAD_CRASH : PAD_HTOM;
    else if (held_yaw >= Y305 && held_yaw <= Y340)
      zone = (held_pitch > P50) ? PAD_RIDE : PAD_MTOM;
    else if (held_yaw >= Y200 && held_yaw <= Y305)
      zone = (held_pitch > P30) ? PAD_RIDE : PAD_LTOM;
    else
      zone = PAD_NONE;
  end

  assign fire   = (mode == MODE_GYRO) && (rate < hit_threshold) && !latched;
  assign rearm  = (mode == MODE_GYRO) && (rate >= hit_threshold) && latched;
  assign drum_v = fire ? zone : PAD_NONE;
  assign hit_n  = fire ? 1'b1 : (rearm ? 1'b0 : hit_flag);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      m_tvalid      <= 1'b0;
      yaw_offset    <= '0;
      hit_threshold <= -16'sd5000;
      held_yaw      <= '0;
      held_pitch    <= '0;
      latched       <= 1'b0;
      hit_flag      <= 1'b0;
      last_drum     <= PAD_NONE;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_YAW_OFFSET:    yaw_offset    <= cfg_data[14:0];
          REG_HIT_THRESHOLD: hit_threshold <= cfg_data;
          default: ;
        endcase
      end
      // FIN reloads the register itself when the word drains
      if (m_tvalid && m_tready && state != FIN)
        m_tvalid <= 1'b0;
      prod <= mul_a * mul_b;

      case (state)
        IDLE: begin
          if (s_tvalid) begin
            mode <= s_tuser;
            qr   <= s_tdata[15:0];
            qi   <= s_tdata[31:16];
            qj   <= s_tdata[47:32];
            qk   <= s_tdata[63:48];
            rate <= s_tdata[79:64];
            mcnt <= '0;
            state <= (s_tuser == MODE_ORIENT) ? MUL : FIN;
          end
        end
        MUL: begin
          // product of pair n is registered in prod and read back at count n+1
          case (mcnt)
            3'd1: acc_p <= p34;
            3'd2: acc_p <= acc_p - p34;
            3'd3: acc_y <= p34;
            3'd4: acc_y <= acc_y + p34;
            3'd5: acc_c <= p34;
            3'd6: acc_c <= acc_c + p34;
            default: ;
          endcase
          if (mcnt == 3'd6)
            state <= SQ;
          else
            mcnt <= mcnt + 1'b1;
        end
        SQ: begin
          if (sinp >= 35'sd268435456) begin
            held_pitch <= P90;
            state <= YST;
          end else if (sinp <= -35'sd268435456) begin
            held_pitch <= -P90;
            state <= YST;
          end else begin
            state <= SQW;
          end
        end
        SQW: begin
          isq_v   <= (57'd1 << 56) - 57'(prod);
          isq_res <= '0;
          isq_one <= 57'd1 << 56;
          icnt    <= '0;
          state   <= ISQ;
        end
        ISQ: begin
          if ({1'b0, isq_v} >= isq_t) begin
            isq_v   <= 57'({1'b0, isq_v} - isq_t);
            isq_res <= (isq_res >> 1) + isq_one;
          end else begin
            isq_res <= isq_res >> 1;
          end
          isq_one <= isq_one >> 2;
          if (icnt == 5'(ISQ_STEPS - 1))
            state <= PST;
          else
            icnt <= icnt + 1'b1;
        end
        PST: state <= PWT;
        PWT: begin
          if (cord_done) begin
            held_pitch <= cord_units;
            state <= YST;
          end
        end
        YST: state <= YWT;
        YWT: begin
          if (cord_done) begin
            wrap_v <= WRAP_W'(cord_units) - WRAP_W'(signed'({1'b0, yaw_offset}));
            state  <= WRAP;
          end
        end
        WRAP: begin
          if (wrap_v < 0)
            wrap_v <= wrap_v + FULL;
          else if (wrap_v >= FULL)
            wrap_v <= wrap_v - FULL;
          else begin
            held_yaw <= wrap_v;
            state <= FIN;
          end
        end
        FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, held_pitch[13:0], held_yaw[14:0], hit_n, drum_v};
            hit_flag <= hit_n;
            if (fire)
              latched <= 1'b1;
            else if (rearm)
              latched <= 1'b0;
            last_drum <= (drum_v != PAD_NONE) ? drum_v : last_drum;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `OGHC_ASSERT(a_load_from_fin, clk, rst, $rose(m_tvalid) |-> $past(state == FIN), "stray load")
  `OGHC_ASSERT(a_yaw_range, clk, rst, (held_yaw >= 0) && (held_yaw < FULL), "yaw range")
  `OGHC_ASSERT(a_fast_path, clk, rst, fast_in |=> (state == FIN), "slow non-orientation word")
  `OGHC_ASSERT_NR(a_reset, clk, rst |=> (!m_tvalid && state == IDLE && !latched), "reset state")

endmodule

### test/orientation_gated_hit_classifier_top_checker.sv
// Scoreboard for the hit classifier: predicts each result word and compares it.
`timescale 1ns / 1ps
module orientation_gated_hit_classifier_top_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [79:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_data,
  output int          mismatch_count,
  output int          words_due
);
  import oghc_pkg::*;

  // first member sits in the top bits, so drum goes last
  typedef struct packed {
    logic signed [13:0] pitch_now;
    logic [14:0]        yaw_now;
    logic               hit_active;
    logic [2:0]         drum;
  } hit_word_t;

  localparam longint ATAN_STEP_Q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0};
  localparam longint ONE_Q28 = 64'sd1 <<< 28;
  localparam longint FULL_TURN = 64'sd360 <<< ANGLE_FRAC_BITS;

  hit_word_t   due_words[$];
  logic [14:0] offset_reg;
  logic signed [15:0] threshold_reg;
  longint      yaw_held, pitch_held;
  logic        disarmed, hit_flag;
  logic [2:0]  last_zone;

  function automatic longint vector_angle(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 64'sd90 <<< 16;
      end else begin
        t = x; x = -y; y = t; z = -(64'sd90 <<< 16);
      end
    end
    for (int i = 0; i < NSTEP; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_STEP_Q16[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_STEP_Q16[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint q16_to_units(longint a);
    return (a + (64'sd1 <<< (SH - 1))) >>> SH;
  endfunction

  function automatic logic [2:0] zone_of(longint y, longint p);
    longint d20, d120, d200, d305, d340, d30, d50;
    d20 = 20 << ANGLE_FRAC_BITS;   d120 = 120 << ANGLE_FRAC_BITS;
    d200 = 200 << ANGLE_FRAC_BITS; d305 = 305 << ANGLE_FRAC_BITS;
    d340 = 340 << ANGLE_FRAC_BITS; d30 = 30 << ANGLE_FRAC_BITS;
    d50 = 50 << ANGLE_FRAC_BITS;
    if (y >= d20 && y <= d120) return PAD_SNARE;
    if (y >= d340 || y <= d20) return (p > d50) ? PAD_CRASH : PAD_HTOM;
    if (y >= d305 && y <= d340) return (p > d50) ? PAD_RIDE : PAD_MTOM;
    if (y >= d200 && y <= d305) return (p > d30) ? PAD_RIDE : PAD_LTOM;
    return PAD_NONE;
  endfunction

  function automatic void take_quaternion(input logic [79:0] d);
    longint r, qi, qj, qk, sinp, siny, cosy, c, yaw;
    r  = longint'($signed(d[15:0]));
    qi = longint'($signed(d[31:16]));
    qj = longint'($signed(d[47:32]));
    qk = longint'($signed(d[63:48]));
    sinp = 2 * (r * qj - qk * qi);
    siny = 2 * (r * qk + qi * qj);
    cosy = ONE_Q28 - 2 * (qj * qj + qk * qk);
    if (sinp >= ONE_Q28) pitch_held = 90 << ANGLE_FRAC_BITS;
    else if (sinp <= -ONE_Q28) pitch_held = -(90 << ANGLE_FRAC_BITS);
    else begin
      c = longint'(root64((64'd1 << 56) - longint'(sinp * sinp)));
      pitch_held = q16_to_units(vector_angle(sinp, c));
    end
    yaw = q16_to_units(vector_angle(siny, cosy)) - longint'(offset_reg);
    yaw = yaw % FULL_TURN;
    if (yaw < 0) yaw += FULL_TURN;
    yaw_held = yaw;
  endfunction

  function automatic hit_word_t step_word(input logic [1:0] mode, input logic [79:0] d);
    hit_word_t w;
    longint rate;
    w.drum = PAD_NONE;
    if (mode == MODE_ORIENT) take_quaternion(d);
    else if (mode == MODE_GYRO) begin
      rate = longint'($signed(d[79:64]));
      if (rate < longint'(threshold_reg) && !disarmed) begin
        hit_flag = 1'b1;
        disarmed = 1'b1;
        w.drum = zone_of(yaw_held, pitch_held);
        if (w.drum != PAD_NONE) last_zone = w.drum;
      end else if (rate >= longint'(threshold_reg) && disarmed) begin
        disarmed = 1'b0;
        hit_flag = 1'b0;
      end
    end
    w.hit_active = hit_flag;
    w.yaw_now = yaw_held[14:0];
    w.pitch_now = pitch_held[13:0];
    return w;
  endfunction

  always @(posedge clk) begin
    hit_word_t want, got;
    int errs;
    errs = 0;
    if (rst) begin
      threshold_reg = -16'sd5000;
      offset_reg = '0;
      yaw_held = 0; pitch_held = 0;
      disarmed = 1'b0; hit_flag = 1'b0; last_zone = PAD_NONE;
      due_words.delete();
      mismatch_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_YAW_OFFSET) offset_reg = cfg_data[14:0];
        else threshold_reg = $signed(cfg_data);
      end
      if (s_tvalid && s_tready) due_words.push_back(step_word(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        got = hit_word_t'(m_tdata[32:0]);
        if (due_words.size() == 0) begin
          $error("result word with none expected: %h", m_tdata);
          errs = errs + 1;
        end else begin
          want = due_words.pop_front();
          if (got.drum !== want.drum) begin
            $error("drum: expected %0d, got %0d", want.drum, got.drum);
            errs = errs + 1;
          end
          if (got.hit_active !== want.hit_active) begin
            $error("hit_active: expected %0d, got %0d", want.hit_active, got.hit_active);
            errs = errs + 1;
          end
          if (got.yaw_now !== want.yaw_now) begin
            $error("yaw_now: expected %0d, got %0d", want.yaw_now, got.yaw_now);
            errs = errs + 1;
          end
          if (got.pitch_now !== want.pitch_now) begin
            $error("pitch_now: expected %0d, got %0d", want.pitch_now, got.pitch_now);
            errs = errs + 1;
          end
        end
      end
      mismatch_count <= mismatch_count + errs;
    end
    words_due <= due_words.size();
  end

endmodule

### test/orientation_gated_hit_classifier_top_test.sv
// Stimulus and verdict for the orientation gated hit classifier.
`timescale 1ns / 1ps
module orientation_gated_hit_classifier_top_test;
  import oghc_pkg::*;

  localparam logic [1:0] MODE_OTHER = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;   // q_real, q_i, q_j, q_k, rate_y
  logic [1:0]  s_tuser = '0;   // mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // drum, hit_active, yaw_now, pitch_now, zero pad
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [15:0] cfg_data = '0;
  int          mismatch_count;
  int          words_due;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  orientation_gated_hit_classifier_top dut (.*);
  orientation_gated_hit_classifier_top_checker scoreboard (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk)
    m_tready <= rst ? 1'b1 : ($urandom_range(99) >= recv_stall_pct);

  task automatic send(input logic [1:0] mode, input logic [79:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic quat(input int r, input int i, input int j, input int k);
    send(MODE_ORIENT, {16'(0), 16'(k), 16'(j), 16'(i), 16'(r)});
  endtask

  task automatic gyro(input int rate);
    send(MODE_GYRO, {16'(rate), 64'($urandom) << 32 | 64'($urandom)});
  endtask

  function automatic int q14(input real v);
    int n;
    n = int'(v * 16384.0);
    if (n > 32767) n = 32767;
    if (n < -32768) n = -32768;
    return n;
  endfunction

  // unit quaternion for a yaw then pitch rotation, degrees
  task automatic aim(input real yaw_deg, input real pitch_deg);
    real cy, sy, cp, sp, h;
    h = 3.14159265358979 / 360.0;
    cy = $cos(yaw_deg * h); sy = $sin(yaw_deg * h);
    cp = $cos(pitch_deg * h); sp = $sin(pitch_deg * h);
    quat(q14(cy * cp), q14(-sy * sp), q14(cy * sp), q14(sy * cp));
  endtask

  task automatic drain_and_set(input int offset, input int threshold);
    s_tvalid <= 1'b0;
    // let the count catch the last accepted word first
    @(posedge clk);
    while (words_due != 0 || m_tvalid) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= REG_YAW_OFFSET; cfg_data <= 16'(offset);
    @(posedge clk);
    cfg_addr <= REG_HIT_THRESHOLD; cfg_data <= 16'(threshold);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      quat($urandom_range(65535), $urandom_range(65535),
           $urandom_range(65535), $urandom_range(65535));
    end else if (pick < 22) begin
      send(pick[0] ? MODE_OTHER : MODE_SPARE, 80'({$urandom, $urandom, $urandom}));
    end else if (pick < 30) begin
      gyro($urandom_range(65535));
    end else begin
      // aim, strike, release: the path that reaches zone decisions
      aim(real'($urandom_range(3599)) / 10.0, real'($urandom_range(1900)) / 10.0 - 95.0);
      if ($urandom_range(3) == 0) gyro(-32768 + $urandom_range(200));
      else gyro(-5001 - $urandom_range(20000));
      gyro(-4999 + $urandom_range(30000));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    quat(0, 0, 0, 0);
    quat(16384, 0, 0, 0);
    quat(0, 0, 0, 16384);                 // yaw on the negative x axis
    quat(16384, 0, 16384, 0);             // pitch pinned high
    quat(16384, 0, -16384, 0);            // pitch pinned low
    quat(32767, 32767, 32767, 32767);
    quat(-32768, -32768, -32768, -32768);
    send(MODE_OTHER, {80{1'b1}});
    send(MODE_SPARE, '0);
    aim(60.0, 0.0);   gyro(-32768); gyro(-32768); gyro(32767);
    aim(5.0, 70.0);   gyro(-6000);  gyro(-5000);
    aim(320.0, 10.0); gyro(-6000);  gyro(0);
    aim(250.0, 40.0); gyro(-6000);  gyro(0);
    aim(160.0, 0.0);  gyro(-6000);  gyro(-7000); gyro(0);

    drain_and_set(23039, 32767);
    for (int p = 0; p < 6; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      for (int n = 0; n < 104; n++) random_word();
      case (p)
        0: drain_and_set(32767, -32768);
        1: drain_and_set(0, -5000);
        2: drain_and_set(11520, 0);
        default: drain_and_set($urandom_range(23039), -$urandom_range(20000));
      endcase
    end

    s_tvalid <= 1'b0;
    while (words_due != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #60ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
